### design/shabs_pkg.sv
package shabs_pkg;

  localparam int unsigned WIN_DEPTH = 16;
  localparam int unsigned WIN_AW    = 4;

  localparam logic [6:0] PAD_LEN_POS = 7'd56;
  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [7:0] PAD_MARK    = 8'h80;

  localparam logic [WIN_AW-1:0] LEN_HI_ADDR = 4'd14;
  localparam logic [WIN_AW-1:0] LEN_LO_ADDR = 4'd15;

  typedef logic [7:0][31:0] vars_t;

  typedef struct packed {
    logic              we;
    logic [WIN_AW-1:0] addr;
    logic [3:0]        be;
    logic [31:0]       data;
  } wr_t;

  localparam vars_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

### design/shabs_wram.sv
module shabs_wram
  import shabs_pkg::*;
(
  input  logic              clk,
  input  wr_t               wr,
  input  logic [WIN_AW-1:0] ra_addr,
  input  logic [WIN_AW-1:0] rb_addr,
  output logic [31:0]       ra_data,
  output logic [31:0]       rb_data
);

  logic [31:0] mem [WIN_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      for (int i = 0; i < 4; i++) begin
        if (wr.be[i]) begin
          mem[wr.addr][8*i +: 8] <= wr.data[8*i +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

### design/shabs_round.sv
module shabs_round
  import shabs_pkg::*;
(
  input  vars_t       vars_i,
  input  logic        sched_en,
  input  logic [31:0] w15,
  input  logic [31:0] w7_or_wt,
  input  logic [31:0] w16,
  input  logic [31:0] w2,
  input  logic [31:0] k,
  output logic [31:0] wt,
  output vars_t       vars_o
);

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] mj;

  assign wt = sched_en ? (w16 + sml_sig0(w15) + w7_or_wt + sml_sig1(w2)) : w7_or_wt;

  assign ch = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
  assign mj = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
  assign t1 = vars_i[7] + big_sig1(vars_i[4]) + ch + k + wt;
  assign t2 = big_sig0(vars_i[0]) + mj;

  always_comb begin
    vars_o[7] = vars_i[6];
    vars_o[6] = vars_i[5];
    vars_o[5] = vars_i[4];
    vars_o[4] = vars_i[3] + t1;
    vars_o[3] = vars_i[2];
    vars_o[2] = vars_i[1];
    vars_o[1] = vars_i[0];
    vars_o[0] = t1 + t2;
  end

endmodule

### design/sha256_byte_stream_hasher_core.sv
// Channel  Dir  Ports                        Contents
// in       in   in_tvalid/tready/tdata/tuser tdata: data_byte; tuser: kind
// out      out  out_tvalid/tready/tdata/     tdata: digest_word; tuser: word_index;
//               tuser/tlast                  tlast: last
// An absorb item writes one byte into the window; the 64th byte of a block
// then starts a compression (setup, 64 rounds at one per cycle, chain update).
// A finish item writes one pad byte per cycle, two length words, runs one or
// two compressions, then offers eight digest items, one per cycle with out_tready.
// Synchronous active-low reset loads the initial hash and clears counters.
// in_tready is low during compression, padding and digest output; a digest
// item holds until out_tready takes it.
module sha256_byte_stream_hasher_core
  import shabs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PAD    = 3'd1;
  localparam logic [2:0] S_LEN_HI = 3'd2;
  localparam logic [2:0] S_LEN_LO = 3'd3;
  localparam logic [2:0] S_PREP   = 3'd4;
  localparam logic [2:0] S_ROUND  = 3'd5;
  localparam logic [2:0] S_FINAL  = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] len_r, len_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic        fin_r, fin_nxt;
  logic        two_r, two_nxt;
  logic [5:0]  t_r, t_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  vars_t       vars_r, vars_nxt;
  vars_t       chain_r, chain_nxt;
  logic [31:0] w16_r;
  logic [31:0] wm1_r;
  logic [31:0] wm2_r;

  wr_t               wr;
  logic [WIN_AW-1:0] ra_addr;
  logic [WIN_AW-1:0] rb_addr;
  logic [31:0]       ra_data;
  logic [31:0]       rb_data;
  logic [31:0]       wt;
  vars_t             vars_rnd;
  logic              in_acc;
  logic              out_acc;
  logic [6:0]        pad_lim;

  shabs_wram u_wram (
    .clk     (clk),
    .wr      (wr),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  shabs_round u_round (
    .vars_i   (vars_r),
    .sched_en (t_r[5] | t_r[4]),
    .w15      (ra_data),
    .w7_or_wt (rb_data),
    .w16      (w16_r),
    .w2       (wm2_r),
    .k        (round_k(t_r)),
    .wt       (wt),
    .vars_o   (vars_rnd)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_acc    = out_tvalid & out_tready;
  assign out_tdata  = chain_r[oidx_r];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 3'd7);
  assign pad_lim    = two_r ? BLOCK_BYTES : PAD_LEN_POS;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    fin_nxt   = fin_r;
    two_nxt   = two_r;
    t_nxt     = t_r;
    oidx_nxt  = oidx_r;
    vars_nxt  = vars_r;
    chain_nxt = chain_r;
    wr        = '0;
    ra_addr   = t_r[3:0] + 4'd2;
    rb_addr   = (t_r < 6'd15) ? (t_r[3:0] + 4'd1) : (t_r[3:0] + 4'd10);
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          wr.we   = 1'b1;
          wr.addr = fill_r[5:2];
          wr.be   = 4'b1000 >> fill_r[1:0];
          if (!in_tuser) begin
            wr.data  = {4{in_tdata}};
            len_nxt  = len_r + 64'd8;
            fill_nxt = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              state_nxt = S_PREP;
            end
          end else begin
            wr.data   = {4{PAD_MARK}};
            pos_nxt   = {1'b0, fill_r} + 7'd1;
            fin_nxt   = 1'b1;
            two_nxt   = (fill_r[5:3] == 3'b111);
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (pos_r == pad_lim) begin
          state_nxt = two_r ? S_PREP : S_LEN_HI;
        end else begin
          wr.we   = 1'b1;
          wr.addr = pos_r[5:2];
          wr.be   = 4'b1000 >> pos_r[1:0];
          wr.data = '0;
          pos_nxt = pos_r + 7'd1;
        end
      end
      S_LEN_HI: begin
        wr.we     = 1'b1;
        wr.addr   = LEN_HI_ADDR;
        wr.be     = 4'b1111;
        wr.data   = len_r[63:32];
        state_nxt = S_LEN_LO;
      end
      S_LEN_LO: begin
        wr.we     = 1'b1;
        wr.addr   = LEN_LO_ADDR;
        wr.be     = 4'b1111;
        wr.data   = len_r[31:0];
        state_nxt = S_PREP;
      end
      S_PREP: begin
        ra_addr   = 4'd1;
        rb_addr   = 4'd0;
        vars_nxt  = chain_r;
        t_nxt     = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        wr.we    = t_r[5] | t_r[4];
        wr.addr  = t_r[3:0];
        wr.be    = 4'b1111;
        wr.data  = wt;
        vars_nxt = vars_rnd;
        t_nxt    = t_r + 6'd1;
        if (t_r == 6'd63) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        for (int j = 0; j < 8; j++) begin
          chain_nxt[j] = chain_r[j] + vars_r[j];
        end
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (two_r) begin
          two_nxt   = 1'b0;
          pos_nxt   = '0;
          state_nxt = S_PAD;
        end else begin
          oidx_nxt  = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            chain_nxt = INIT_H;
            fill_nxt  = '0;
            len_nxt   = '0;
            fin_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      fin_r   <= 1'b0;
      two_r   <= 1'b0;
      t_r     <= '0;
      oidx_r  <= '0;
      chain_r <= INIT_H;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      fin_r   <= fin_nxt;
      two_r   <= two_nxt;
      t_r     <= t_nxt;
      oidx_r  <= oidx_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vars_r <= vars_nxt;
    if (state_r == S_ROUND) begin
      w16_r <= ra_data;
      wm1_r <= wt;
      wm2_r <= wm1_r;
    end
  end

endmodule

### dv/tb_top.sv
module tb_top;

  localparam logic KIND_ABSORB = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam int ITEM_TARGET  = 460;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 100;
  localparam int PRINT_LIMIT  = 50;

  localparam logic [0:7][31:0] HASH_START = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_CONST = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_ALTERNATE
  } rx_mode_e;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  class digest_tracker;
    logic [31:0]  chain [8];
    logic [7:0]   msg_block [64];
    int unsigned  fill;
    logic [63:0]  bit_len;
    digest_item_t pending_words [$];
    int           fail_count;
    int           messages;
    int           bytes_absorbed;
    int           words_checked;

    function new();
      int j;
      for (j = 0; j < 8; j++) chain[j] = HASH_START[j];
      for (j = 0; j < 64; j++) msg_block[j] = 8'h00;
      fill = 0;
      bit_len = '0;
      fail_count = 0;
      messages = 0;
      bytes_absorbed = 0;
      words_checked = 0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress_block();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wt, s0, s1, t1, t2, x15, x2;
      int t;
      for (t = 0; t < 16; t++)
        w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
      for (t = 0; t < 8; t++) v[t] = chain[t];
      for (t = 0; t < 64; t++) begin
        if (t < 16) begin
          wt = w[t];
        end else begin
          x15 = w[(t - 15) % 16];
          x2  = w[(t - 2) % 16];
          s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
          s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
          wt = w[t % 16] + s0 + w[(t - 7) % 16] + s1;
          w[t % 16] = wt;
        end
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + wt;
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (t = 0; t < 8; t++) chain[t] = chain[t] + v[t];
    endfunction

    function void take_input(logic kind, logic [7:0] data_byte);
      int unsigned pos;
      int j;
      digest_item_t item;
      if (kind == KIND_ABSORB) begin
        msg_block[fill] = data_byte;
        bit_len = bit_len + 64'd8;
        bytes_absorbed++;
        fill++;
        if (fill == 64) begin
          compress_block();
          fill = 0;
        end
        return;
      end
      pos = fill;
      msg_block[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          msg_block[pos] = 8'h00;
          pos++;
        end
        compress_block();
        pos = 0;
      end
      while (pos < 56) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      for (j = 0; j < 8; j++) msg_block[56 + j] = bit_len[63 - 8*j -: 8];
      compress_block();
      for (j = 0; j < 8; j++) begin
        item.word  = chain[j];
        item.index = j[2:0];
        item.last  = (j == 7);
        pending_words.push_back(item);
      end
      for (j = 0; j < 8; j++) chain[j] = HASH_START[j];
      fill = 0;
      bit_len = '0;
      messages++;
    endfunction

    task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
        $display("ERROR %0t: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    task check_digest_item(logic [31:0] word, logic [2:0] index, logic last);
      digest_item_t want;
      if (pending_words.size() == 0) begin
        report_mismatch("digest item with none pending", '0, word);
        return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (word !== want.word) report_mismatch("digest_word", want.word, word);
      if (index !== want.index) report_mismatch("word_index", want.index, index);
      if (last !== want.last) report_mismatch("last", want.last, last);
    endtask

    task flag_leftovers();
      digest_item_t want;
      while (pending_words.size() != 0) begin
        want = pending_words.pop_front();
        report_mismatch("digest word never delivered", want.word, '0);
      end
    endtask

    function int outstanding();
      return pending_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  digest_tracker board;
  int            items_sent = 0;
  int            burst_left = 0;
  bit            hold_req = 1'b0;
  int            hold_left = 0;
  int            holds_done = 0;
  int            mode_left = 0;
  int            rx_tick = 0;
  rx_mode_e      rx_mode = RX_STREAM;

  sha256_byte_stream_hasher_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // receiver ready pattern; a requested hold-off overrides it
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(3, 0));
        mode_left = $urandom_range(60, 10);
      end
      mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_STREAM:    out_tready <= 1'b1;
        RX_COIN:      out_tready <= 1'($urandom_range(1, 0));
        RX_SPARSE:    out_tready <= ($urandom_range(3, 0) == 0);
        default:      out_tready <= rx_tick[0];
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_digest_item(out_tdata, out_tuser, out_tlast);
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("ERROR: no item moved for %0d cycles", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input logic kind, input logic [7:0] data_byte);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data_byte;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.take_input(kind, data_byte);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom_range(255, 0));
        in_tuser  <= 1'($urandom_range(1, 0));
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_message(input int len);
    int i;
    for (i = 0; i < len; i++) send_item(KIND_ABSORB, 8'($urandom_range(255, 0)));
    send_item(KIND_FINISH, 8'($urandom_range(255, 0)));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (board.outstanding() != 0) @(negedge clk);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(9, 0);
    if (r < 5) return $urandom_range(20, 0);
    if (r < 9) return $urandom_range(70, 50);
    return $urandom_range(130, 65);
  endfunction

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty message, data byte on the finish item must be ignored
    send_item(KIND_FINISH, 8'hff);
    send_item(KIND_ABSORB, 8'h00);
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_ABSORB, 8'hff);
    send_item(KIND_FINISH, 8'h5a);
    send_item(KIND_ABSORB, 8'h61);
    send_item(KIND_ABSORB, 8'h62);
    send_item(KIND_ABSORB, 8'h63);
    send_item(KIND_FINISH, 8'hff);
    // back-to-back finish: state must be back at the initial hash
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_ABSORB, 8'h80);
    send_item(KIND_ABSORB, 8'h7f);
    send_item(KIND_ABSORB, 8'h01);
    send_item(KIND_ABSORB, 8'hfe);
    send_item(KIND_FINISH, 8'h80);

    // padding boundaries: one pad block, two pad blocks, full block then pad
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);

    drain_results();
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    send_message(12);
    send_message(30);

    while (items_sent < ITEM_TARGET) send_message(pick_length());

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    board.flag_leftovers();

    $display("Covered %0d messages, %0d bytes absorbed, %0d digest words checked",
             board.messages, board.bytes_absorbed, board.words_checked);
    $display("Included 55/56/63/64-byte fills, empty messages and %0d long receiver hold-off",
             holds_done);
    if (board.fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
